@@ sv/sensor_scan_sequencer_core_macros.svh @@
// Assertion macros shared by the sensor scan sequencer RTL.
`ifndef SENSOR_SCAN_SEQUENCER_CORE_MACROS_SVH
`define SENSOR_SCAN_SEQUENCER_CORE_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define SSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define SSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/sss_pkg.sv @@
// Types and constants of the sensor scan sequencer.
`default_nettype none
package sss_pkg;

    localparam int SAMPLE_W = 10;
    localparam int CHAN_W   = 3;

    typedef enum logic [1:0] {
        REQ_NORMAL = 2'd0,
        REQ_FULL   = 2'd1,
        REQ_KNOCK  = 2'd2,
        REQ_DONE   = 2'd3
    } req_kind_t;

    localparam logic [CHAN_W-1:0] CH_PRESSURE = 3'd0;
    localparam logic [CHAN_W-1:0] CH_BATTERY  = 3'd1;
    localparam logic [CHAN_W-1:0] CH_TEMP     = 3'd2;
    localparam logic [CHAN_W-1:0] CH_DUMMY    = 3'd3;
    localparam logic [CHAN_W-1:0] CH_KNOCK    = 3'd4;

    typedef struct packed {
        req_kind_t           req_type;
        logic [SAMPLE_W-1:0] sample;
    } req_t;

    typedef struct packed {
        logic                start_conversion;
        logic [CHAN_W-1:0]   next_channel;
        logic                ready_res;
        logic [SAMPLE_W-1:0] pressure_value;
        logic [SAMPLE_W-1:0] battery_value;
        logic [SAMPLE_W-1:0] coolant_value;
        logic [SAMPLE_W-1:0] knock_level;
    } res_t;

endpackage
`default_nettype wire

@@ sv/sensor_scan_sequencer_core.sv @@
// Top level of the sensor scan sequencer: channel sequencing and sample store.
`default_nettype none
// Sensor scan sequencer. Each request transaction (a normal, full or knock
// start, or a conversion-done event carrying a sample) updates the channel
// selector, the idle flag and the four sample registers, and its result
// transaction appears in the result register in the following cycle.
// One transaction is accepted per cycle; req_ready drops only while a
// result waits in the result register and res_ready is low. The result
// register is the only stage. SAMPLE_BITS sets how many low bits of each
// sample are kept (at most the 10-bit field width).
`include "sensor_scan_sequencer_core_macros.svh"
module sensor_scan_sequencer_core #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire sss_pkg::req_t req,
    output logic               res_valid,
    input  wire logic          res_ready,
    output sss_pkg::res_t      res
);

    localparam int KEEP_BITS = (SAMPLE_BITS < sss_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                 : sss_pkg::SAMPLE_W;

    logic [sss_pkg::CHAN_W-1:0] chan_reg, chan_next;
    logic                       idle_reg, idle_next;
    logic                       full_reg, full_next;
    logic [KEEP_BITS-1:0]       pressure_reg, pressure_next;
    logic [KEEP_BITS-1:0]       battery_reg, battery_next;
    logic [KEEP_BITS-1:0]       coolant_reg, coolant_next;
    logic [KEEP_BITS-1:0]       knock_reg, knock_next;
    logic                       start_next;
    logic [KEEP_BITS-1:0]       value;
    logic                       accept;
    logic                       res_valid_reg;
    sss_pkg::res_t              res_reg, res_next;

    assign req_ready = !res_valid_reg || res_ready;
    assign accept    = req_valid && req_ready;
    assign value     = req.sample[KEEP_BITS-1:0];
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        chan_next     = chan_reg;
        idle_next     = idle_reg;
        full_next     = full_reg;
        pressure_next = pressure_reg;
        battery_next  = battery_reg;
        coolant_next  = coolant_reg;
        knock_next    = knock_reg;
        start_next    = 1'b0;
        case (req.req_type)
            sss_pkg::REQ_NORMAL, sss_pkg::REQ_FULL, sss_pkg::REQ_KNOCK:
            begin
                // A full start latches its flag even while busy.
                if (req.req_type == sss_pkg::REQ_FULL)
                begin
                    full_next = 1'b1;
                end
                if (idle_reg)
                begin
                    idle_next  = 1'b0;
                    start_next = 1'b1;
                    chan_next  = (req.req_type == sss_pkg::REQ_KNOCK) ? sss_pkg::CH_DUMMY
                                                                     : sss_pkg::CH_PRESSURE;
                end
            end
            sss_pkg::REQ_DONE:
            begin
                if (!idle_reg)
                begin
                    case (chan_reg)
                        sss_pkg::CH_PRESSURE:
                        begin
                            pressure_next = value;
                            chan_next     = sss_pkg::CH_BATTERY;
                            start_next    = 1'b1;
                        end
                        sss_pkg::CH_BATTERY:
                        begin
                            battery_next = value;
                            chan_next    = sss_pkg::CH_TEMP;
                            start_next   = 1'b1;
                        end
                        sss_pkg::CH_TEMP:
                        begin
                            coolant_next = value;
                            if (full_reg)
                            begin
                                full_next  = 1'b0;
                                chan_next  = sss_pkg::CH_KNOCK;
                                start_next = 1'b1;
                            end
                            else
                            begin
                                chan_next = sss_pkg::CH_PRESSURE;
                                idle_next = 1'b1;
                            end
                        end
                        sss_pkg::CH_DUMMY:
                        begin
                            // Drop the throwaway sample.
                            chan_next  = sss_pkg::CH_KNOCK;
                            start_next = 1'b1;
                        end
                        sss_pkg::CH_KNOCK:
                        begin
                            knock_next = value;
                            idle_next  = 1'b1;
                        end
                        default:
                        begin
                            // Unreachable selector: hold everything.
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase

        res_next.start_conversion = start_next;
        res_next.next_channel     = chan_next;
        res_next.ready_res        = idle_next;
        res_next.pressure_value   = sss_pkg::SAMPLE_W'(pressure_next);
        res_next.battery_value    = sss_pkg::SAMPLE_W'(battery_next);
        res_next.coolant_value    = sss_pkg::SAMPLE_W'(coolant_next);
        res_next.knock_level      = sss_pkg::SAMPLE_W'(knock_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg      <= sss_pkg::CH_PRESSURE;
            idle_reg      <= 1'b1;
            full_reg      <= 1'b0;
            pressure_reg  <= '0;
            battery_reg   <= '0;
            coolant_reg   <= '0;
            knock_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                chan_reg     <= chan_next;
                idle_reg     <= idle_next;
                full_reg     <= full_next;
                pressure_reg <= pressure_next;
                battery_reg  <= battery_next;
                coolant_reg  <= coolant_next;
                knock_reg    <= knock_next;
            end
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    `SSS_ASSERT_NOW(a_idle_chan, idle_reg,
        (chan_reg == sss_pkg::CH_PRESSURE) || (chan_reg == sss_pkg::CH_KNOCK),
        "idle with channel other than pressure or knock")
    `SSS_ASSERT_NEXT(a_knock_start, accept && idle_reg && (req.req_type == sss_pkg::REQ_KNOCK),
        (chan_reg == sss_pkg::CH_DUMMY) && !idle_reg && res_reg.start_conversion,
        "knock start did not select dummy channel")
    `SSS_ASSERT_NOW(a_start_busy, res_valid_reg && res_reg.start_conversion,
        !res_reg.ready_res, "conversion started while reporting ready")

endmodule
`default_nettype wire
